// File: hdl/adcbas_pkg.sv
// ----------------------------------------------------------------------------
// adcbas_pkg
// Shared constants, control word type and microcode table for the ADC block
// average smoother.
// ----------------------------------------------------------------------------
package adcbas_pkg;

  localparam int CHANNELS_DEF    = 3;
  localparam int SAMPLE_BITS_DEF = 10;

  localparam int GAIN_W     = 17;
  localparam int COUNT_W    = 7;
  localparam int ANGLE_W    = 17;
  localparam int GAIN_FRAC  = 16;
  localparam int ANGLE_FRAC = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = GAIN_W;

  localparam logic [GAIN_W-1:0]  GAIN_ONE    = 17'd65536;
  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 17'd42598;
  localparam logic [GAIN_W-1:0]  ANGLE_SCALE = 17'd360;
  localparam logic [COUNT_W-1:0] BLOCK_RESET = 7'd100;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_GAIN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'd1;

  // multiplier operand select
  localparam logic [1:0] MUL_NONE       = 2'd0;
  localparam logic [1:0] MUL_GAIN_AVG   = 2'd1;
  localparam logic [1:0] MUL_COMP_LEVEL = 2'd2;
  localparam logic [1:0] MUL_ANGLE      = 2'd3;

  // jump conditions
  localparam logic [2:0] COND_NONE     = 3'd0;
  localparam logic [2:0] COND_NO_FIRE  = 3'd1;
  localparam logic [2:0] COND_EMPTY    = 3'd2;
  localparam logic [2:0] COND_DIV_BUSY = 3'd3;
  localparam logic [2:0] COND_MORE_CH  = 3'd4;
  localparam logic [2:0] COND_OUT_FULL = 3'd5;
  localparam logic [2:0] COND_ALWAYS   = 3'd6;

  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_IDLE      = 4'd0;
  localparam logic [STEP_W-1:0] STEP_DIV_START = 4'd1;
  localparam logic [STEP_W-1:0] STEP_DIV_WAIT  = 4'd2;
  localparam logic [STEP_W-1:0] STEP_MUL_GAIN  = 4'd3;
  localparam logic [STEP_W-1:0] STEP_MUL_COMP  = 4'd4;
  localparam logic [STEP_W-1:0] STEP_LEVEL     = 4'd5;
  localparam logic [STEP_W-1:0] STEP_MUL_ANGLE = 4'd6;
  localparam logic [STEP_W-1:0] STEP_STORE     = 4'd7;
  localparam logic [STEP_W-1:0] STEP_OUT_WAIT  = 4'd8;
  localparam logic [STEP_W-1:0] STEP_OUT_LOAD  = 4'd9;

  typedef struct packed {
    logic              accept;
    logic              div_start;
    logic [1:0]        mul_sel;
    logic              acc_load;
    logic              level_write;
    logic              angle_write;
    logic              ch_advance;
    logic              out_load;
    logic [2:0]        cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  // microcode ROM: next step is target when cond holds, else step + 1
  function automatic ctrl_t ucode_word(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w = '0;
    case (step)
      STEP_IDLE: begin
        w.accept = 1'b1;
        w.cond   = COND_NO_FIRE;
        w.target = STEP_IDLE;
      end
      STEP_DIV_START: begin
        w.div_start = 1'b1;
        w.cond      = COND_EMPTY;
        w.target    = STEP_MUL_ANGLE;
      end
      STEP_DIV_WAIT: begin
        w.cond   = COND_DIV_BUSY;
        w.target = STEP_DIV_WAIT;
      end
      STEP_MUL_GAIN: begin
        w.mul_sel = MUL_GAIN_AVG;
      end
      STEP_MUL_COMP: begin
        w.mul_sel  = MUL_COMP_LEVEL;
        w.acc_load = 1'b1;
      end
      STEP_LEVEL: begin
        w.level_write = 1'b1;
      end
      STEP_MUL_ANGLE: begin
        w.mul_sel = MUL_ANGLE;
      end
      STEP_STORE: begin
        w.angle_write = 1'b1;
        w.ch_advance  = 1'b1;
        w.cond        = COND_MORE_CH;
        w.target      = STEP_DIV_START;
      end
      STEP_OUT_WAIT: begin
        w.cond   = COND_OUT_FULL;
        w.target = STEP_OUT_WAIT;
      end
      STEP_OUT_LOAD: begin
        w.out_load = 1'b1;
        w.cond     = COND_ALWAYS;
        w.target   = STEP_IDLE;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// File: hdl/adc_block_average_smoother.sv
// ----------------------------------------------------------------------------
// adc_block_average_smoother
// Per-channel boxcar averaging of scanned converter samples, first-order
// low-pass smoothing of each block average and conversion to degrees.
// ----------------------------------------------------------------------------
// Samples that do not close a block are accepted back to back. A sample
// that closes a block starts the block-end program and in_ready stays low
//   until it ends: each channel with samples runs the bit-serial divider,
//   the gain and complement multiplies, the level write, the angle multiply
//   and the store; an empty channel skips straight to the angle multiply and
//   the store. Last, the result waits for a free output register and loads.
// Reset: rst is synchronous, active high; clears scan phase, sums, counts,
//   smoothed levels, and loads default gain and block count. No clear pass.
// ----------------------------------------------------------------------------
module adc_block_average_smoother #(
  parameter int CHANNELS    = adcbas_pkg::CHANNELS_DEF,
  parameter int SAMPLE_BITS = adcbas_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // config write port
  input  logic                               cfg_write,
  input  logic [adcbas_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [adcbas_pkg::CFG_DATA_W-1:0]  cfg_data,
  // sample beats
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [SAMPLE_BITS-1:0]             sample,
  // result beats
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [adcbas_pkg::ANGLE_W-1:0]     angle_ch0,
  output logic [adcbas_pkg::ANGLE_W-1:0]     angle_ch1,
  output logic [adcbas_pkg::ANGLE_W-1:0]     angle_ch2
);

  localparam int GAIN_W      = adcbas_pkg::GAIN_W;
  localparam int COUNT_W     = adcbas_pkg::COUNT_W;
  localparam int ANGLE_W     = adcbas_pkg::ANGLE_W;
  localparam int STEP_W      = adcbas_pkg::STEP_W;
  localparam int SUM_W       = SAMPLE_BITS + COUNT_W;
  localparam int LEVEL_W     = SAMPLE_BITS + adcbas_pkg::GAIN_FRAC;
  localparam int PROD_W      = GAIN_W + LEVEL_W;
  localparam int ANGLE_SHIFT = SAMPLE_BITS + adcbas_pkg::ANGLE_FRAC;
  localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PH_W        = $clog2(CHANNELS + 1);

  // config registers
  logic [GAIN_W-1:0]  filter_gain;
  logic [COUNT_W-1:0] block_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_gain <= adcbas_pkg::GAIN_RESET;
      block_count <= adcbas_pkg::BLOCK_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        adcbas_pkg::REG_FILTER_GAIN: filter_gain <= cfg_data[GAIN_W-1:0];
        adcbas_pkg::REG_BLOCK_COUNT: block_count <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // gain above one saturates to one
  logic [GAIN_W-1:0] gain_sat;
  logic [GAIN_W-1:0] gain_comp;
  assign gain_sat  = (filter_gain > adcbas_pkg::GAIN_ONE) ? adcbas_pkg::GAIN_ONE : filter_gain;
  assign gain_comp = adcbas_pkg::GAIN_ONE - gain_sat;

  // sequencer
  logic [STEP_W-1:0]  step;
  logic [STEP_W-1:0]  step_next;
  adcbas_pkg::ctrl_t  ctrl;
  logic               cond_true;
  logic [CH_W-1:0]    ch_idx;

  assign ctrl     = adcbas_pkg::ucode_word(step);
  assign in_ready = ctrl.accept;

  logic in_beat;
  assign in_beat = in_valid && in_ready;

  // scan state and accumulators
  logic [PH_W-1:0]    scan_phase;
  logic [SUM_W-1:0]   sample_sums   [CHANNELS];
  logic [COUNT_W-1:0] sample_counts [CHANNELS];
  logic [LEVEL_W-1:0] smoothed_level[CHANNELS];
  logic [ANGLE_W-1:0] angle_stage   [CHANNELS];

  logic               phase_live;
  logic [CH_W-1:0]    phase_ch;
  logic [COUNT_W-1:0] count0_new;
  logic               block_fire;

  assign phase_live = (scan_phase != '0) && (scan_phase <= PH_W'(CHANNELS));
  assign phase_ch   = CH_W'(scan_phase - PH_W'(1));
  // block check looks at channel 0's count after this beat is counted
  assign count0_new = (phase_live && (phase_ch == '0)) ?
                      (sample_counts[0] + COUNT_W'(1)) : sample_counts[0];
  assign block_fire = (count0_new >= block_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_phase <= '0;
    end else if (in_beat) begin
      if (phase_live && (scan_phase < PH_W'(CHANNELS))) begin
        scan_phase <= scan_phase + PH_W'(1);
      end else begin
        scan_phase <= PH_W'(1);  // wrap, or leave warm-up
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CHANNELS; i++) begin
      if (rst) begin
        sample_sums[i]   <= '0;
        sample_counts[i] <= '0;
      end else if (in_beat && phase_live && (phase_ch == CH_W'(i))) begin
        sample_sums[i]   <= sample_sums[i] + SUM_W'(sample);
        sample_counts[i] <= sample_counts[i] + COUNT_W'(1);
      end else if (ctrl.angle_write && (ch_idx == CH_W'(i))) begin
        sample_sums[i]   <= '0;
        sample_counts[i] <= '0;
      end
    end
  end

  // divider for the block average
  logic             div_busy;
  logic [SUM_W-1:0] div_quo;
  logic             ch_empty;

  assign ch_empty = (sample_counts[ch_idx] == '0);

  adcbas_divider #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (COUNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctrl.div_start && !ch_empty),
    .dividend (sample_sums[ch_idx]),
    .divisor  (sample_counts[ch_idx]),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  // shared multiplier, registered product
  logic [GAIN_W-1:0]  mul_a;
  logic [LEVEL_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;
  logic [LEVEL_W-1:0] acc;

  always_comb begin
    case (ctrl.mul_sel)
      adcbas_pkg::MUL_GAIN_AVG: begin
        mul_a = gain_sat;
        mul_b = LEVEL_W'(div_quo[SAMPLE_BITS-1:0]);
      end
      adcbas_pkg::MUL_COMP_LEVEL: begin
        mul_a = gain_comp;
        mul_b = smoothed_level[ch_idx];
      end
      adcbas_pkg::MUL_ANGLE: begin
        mul_a = adcbas_pkg::ANGLE_SCALE;
        mul_b = smoothed_level[ch_idx];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_sel != adcbas_pkg::MUL_NONE) begin
      prod <= PROD_W'(mul_a * mul_b);
    end
    // g*avg is an exact Q16 value, so it joins the sum without a shift
    if (ctrl.acc_load) begin
      acc <= prod[LEVEL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CHANNELS; i++) begin
      if (rst) begin
        smoothed_level[i] <= '0;
      end else if (ctrl.level_write && (ch_idx == CH_W'(i))) begin
        smoothed_level[i] <= acc + prod[adcbas_pkg::GAIN_FRAC +: LEVEL_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CHANNELS; i++) begin
      if (ctrl.angle_write && (ch_idx == CH_W'(i))) begin
        angle_stage[i] <= prod[ANGLE_SHIFT +: ANGLE_W];
      end
    end
  end

  // output register
  logic               out_full;
  logic [ANGLE_W-1:0] out_angle[CHANNELS];

  assign out_full = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      for (int i = 0; i < CHANNELS; i++) begin
        out_angle[i] <= angle_stage[i];
      end
    end
  end

  assign angle_ch0 = out_angle[0];

  if (CHANNELS > 1) begin : g_ch1
    assign angle_ch1 = out_angle[1];
  end else begin : g_no_ch1
    assign angle_ch1 = '0;
  end

  if (CHANNELS > 2) begin : g_ch2
    assign angle_ch2 = out_angle[2];
  end else begin : g_no_ch2
    assign angle_ch2 = '0;
  end

  // jump logic
  always_comb begin
    case (ctrl.cond)
      adcbas_pkg::COND_NONE:     cond_true = 1'b0;
      adcbas_pkg::COND_NO_FIRE:  cond_true = !(in_beat && block_fire);
      adcbas_pkg::COND_EMPTY:    cond_true = ch_empty;
      adcbas_pkg::COND_DIV_BUSY: cond_true = div_busy;
      adcbas_pkg::COND_MORE_CH:  cond_true = (ch_idx != CH_W'(CHANNELS - 1));
      adcbas_pkg::COND_OUT_FULL: cond_true = out_full;
      adcbas_pkg::COND_ALWAYS:   cond_true = 1'b1;
      default:                   cond_true = 1'b1;
    endcase
    step_next = cond_true ? ctrl.target : (step + STEP_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step   <= adcbas_pkg::STEP_IDLE;
      ch_idx <= '0;
    end else begin
      step <= step_next;
      if (ctrl.ch_advance) begin
        ch_idx <= (ch_idx == CH_W'(CHANNELS - 1)) ? '0 : (ch_idx + CH_W'(1));
      end
    end
  end

endmodule

// File: hdl/adcbas_divider.sv
// ----------------------------------------------------------------------------
// adcbas_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module adcbas_divider #(
  parameter int DIVIDEND_W = 17,
  parameter int DIVISOR_W  = 7
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  busy,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [CNT_W-1:0]     cnt;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] dvs;
  logic [DIVISOR_W:0]   trial;
  logic                 take;

  assign trial = {rem, quotient[DIVIDEND_W-1]};
  assign take  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(DIVIDEND_W);
    end else if (busy) begin
      cnt  <= cnt - CNT_W'(1);
      busy <= (cnt != CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= take ? DIVISOR_W'(trial - {1'b0, dvs}) : trial[DIVISOR_W-1:0];
      quotient <= {quotient[DIVIDEND_W-2:0], take};
    end
  end

endmodule

// File: hdl/adcbas_checker.sv
// ----------------------------------------------------------------------------
// adcbas_checker
// Port-level assertions for the ADC block average smoother, bound to the top.
// ----------------------------------------------------------------------------
module adcbas_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [adcbas_pkg::ANGLE_W-1:0] angle_ch0,
  input logic [adcbas_pkg::ANGLE_W-1:0] angle_ch1,
  input logic [adcbas_pkg::ANGLE_W-1:0] angle_ch2
);

  localparam logic [adcbas_pkg::ANGLE_W-1:0] ANGLE_MAX = 17'd92159;

  // stalled result beat holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      $stable(angle_ch0) && $stable(angle_ch1) && $stable(angle_ch2))
    else $error("result changed while stalled");

  // ready for samples right after reset
  assert property (@(posedge clk) rst |=> in_ready)
    else $error("not ready after reset");

  // the block-end program lies between an accepted sample and a rising result
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result too soon after sample");

  // angles stay below 360 degrees
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (angle_ch0 <= ANGLE_MAX) && (angle_ch1 <= ANGLE_MAX) &&
                  (angle_ch2 <= ANGLE_MAX))
    else $error("angle out of range");

endmodule

bind adc_block_average_smoother adcbas_checker u_adcbas_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .angle_ch0 (angle_ch0),
  .angle_ch1 (angle_ch1),
  .angle_ch2 (angle_ch2)
);

// File: sim/adc_block_average_smoother_tb.sv
// ----------------------------------------------------------------------------
// adc_block_average_smoother_tb
// Self-checking bench for the scanned-channel block averager and smoother.
// Sample beats are fed from a queue and predicted on acceptance. Result beats
// are checked against the oldest predicted angle set. Register settings are
// changed only between phases, while the block is quiet.
// ----------------------------------------------------------------------------
module adc_block_average_smoother_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCH     = adcbas_pkg::CHANNELS_DEF;
  localparam int SBITS   = adcbas_pkg::SAMPLE_BITS_DEF;
  localparam int GAIN_W  = adcbas_pkg::GAIN_W;
  localparam int COUNT_W = adcbas_pkg::COUNT_W;
  localparam int ANGLE_W = adcbas_pkg::ANGLE_W;
  localparam int IDX_W   = adcbas_pkg::CFG_IDX_W;
  localparam int DATA_W  = adcbas_pkg::CFG_DATA_W;
  localparam int LEVEL_W = 26;             // Q10.16 smoothed level
  localparam int QUIET   = 100;            // quiet wait, longer than the block-end program
  localparam int CHOKE   = 600;            // long receiver hold-off

  // one result beat: angle per channel, index = channel
  typedef logic [NCH-1:0][ANGLE_W-1:0] angle_set_t;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               cfg_write = 1'b0;
  logic [IDX_W-1:0]   cfg_index = '0;
  logic [DATA_W-1:0]  cfg_data  = '0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  logic [SBITS-1:0]   sample    = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [ANGLE_W-1:0] angle_ch0;
  logic [ANGLE_W-1:0] angle_ch1;
  logic [ANGLE_W-1:0] angle_ch2;

  always #2 clk = ~clk;

  adc_block_average_smoother i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample    (sample),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .angle_ch0 (angle_ch0),
    .angle_ch1 (angle_ch1),
    .angle_ch2 (angle_ch2)
  );

  // --------------------------------------------------------------------------
  // Shadow of the block: register copies plus scan/accumulator/filter state.
  // --------------------------------------------------------------------------
  logic [GAIN_W-1:0]  gain_reg = adcbas_pkg::GAIN_RESET;
  logic [COUNT_W-1:0] blk_reg  = adcbas_pkg::BLOCK_RESET;
  logic [1:0]         scan_pos = 2'd0;       // 0 = warm-up, then channel + 1
  int unsigned        ch_sum   [NCH] = '{default: 0};
  logic [COUNT_W-1:0] ch_cnt   [NCH] = '{default: '0};
  logic [LEVEL_W-1:0] ch_level [NCH] = '{default: '0};

  logic [SBITS-1:0] sample_queue [$];        // samples not yet offered
  angle_set_t       angle_queue  [$];        // predicted result beats, oldest first

  int  items_sent   = 0;
  int  mismatches   = 0;
  bit  calm         = 1'b0;                  // no idling on either side
  bit  choke_req    = 1'b0;
  bit  choke_done   = 1'b0;
  int  hold_left    = 0;

  // Folds one accepted sample into the shadow state. Returns 1 when the
  // sample closes a block, with the angle set the block must then emit.
  function automatic bit fold_sample(input logic [SBITS-1:0] s, output angle_set_t a);
    logic [63:0] g;
    logic [63:0] acc;
    logic [63:0] wide;
    int unsigned avg;
    int          c;
    a = '0;
    // warm-up beat only moves the scan onto channel 0
    if (scan_pos >= 2'd1 && scan_pos <= 2'(NCH)) begin
      c = int'(scan_pos) - 1;
      ch_sum[c] += s;
      ch_cnt[c] = ch_cnt[c] + 1'b1;
      scan_pos = (scan_pos >= 2'(NCH)) ? 2'd1 : scan_pos + 2'd1;
    end else begin
      scan_pos = 2'd1;
    end
    // block check runs every beat, warm-up included; zero count fires always
    if (ch_cnt[0] < blk_reg) return 1'b0;
    g = (gain_reg > adcbas_pkg::GAIN_ONE) ? 64'(adcbas_pkg::GAIN_ONE) : 64'(gain_reg);
    for (c = 0; c < NCH; c++) begin
      // an empty channel keeps its level but still reports it
      if (ch_cnt[c] != '0) begin
        avg = ch_sum[c] / ch_cnt[c];
        acc = ((g * 64'(avg)) << adcbas_pkg::GAIN_FRAC) +
              (64'(adcbas_pkg::GAIN_ONE) - g) * 64'(ch_level[c]);
        ch_level[c] = LEVEL_W'(acc >> adcbas_pkg::GAIN_FRAC);
      end
      wide = 64'(adcbas_pkg::ANGLE_SCALE) * 64'(ch_level[c]);
      a[c] = ANGLE_W'(wide >> (adcbas_pkg::GAIN_FRAC + 10 - adcbas_pkg::ANGLE_FRAC));
      ch_sum[c] = 0;
      ch_cnt[c] = '0;
    end
    return 1'b1;
  endfunction

  task automatic note_mismatch(input string what, input int c, input int want, input int got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s ch%0d expected %0d got %0d", $realtime, what, c, want, got);
  endtask

  // --------------------------------------------------------------------------
  // Sample driver: holds a beat until accepted, may idle between beats.
  // Prediction happens on the accepting edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : feed
    angle_set_t trio;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        items_sent++;
        if (fold_sample(sample, trio)) angle_queue.push_back(trio);
      end
      if (!in_valid || in_ready) begin
        if (sample_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 18)) begin
          in_valid <= 1'b1;
          sample   <= sample_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor and receiver backpressure. A one-time choke holds off
  // the receiver so the block's output and then its input stall.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    angle_set_t want;
    angle_set_t got;
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got = {angle_ch2, angle_ch1, angle_ch0};
        if (angle_queue.size() == 0) begin
          note_mismatch("unexpected result beat, angle", 0, 0, int'(got[0]));
        end else begin
          want = angle_queue.pop_front();
          for (int c = 0; c < NCH; c++)
            if (got[c] !== want[c]) note_mismatch("angle", c, int'(want[c]), int'(got[c]));
        end
      end
      if (choke_req && !choke_done) begin
        choke_done <= 1'b1;
        hold_left  <= CHOKE;
        out_ready  <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= 18);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequencing helpers (run from the stimulus process)
  // --------------------------------------------------------------------------
  // everything offered, accepted and answered
  task automatic wait_drained();
    do @(negedge clk);
    while (sample_queue.size() != 0 || in_valid || angle_queue.size() != 0);
  endtask

  // drained, then a quiet wait longer than the block-end program
  task automatic settle();
    wait_drained();
    repeat (QUIET) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == adcbas_pkg::REG_FILTER_GAIN) gain_reg = GAIN_W'(val);
    else                                    blk_reg  = val[COUNT_W-1:0];
  endtask

  // block count takes the low bits of the data word
  task automatic apply_settings(input logic [DATA_W-1:0] g, input logic [DATA_W-1:0] b);
    settle();
    write_reg(adcbas_pkg::REG_FILTER_GAIN, g);
    write_reg(adcbas_pkg::REG_BLOCK_COUNT, b);
    @(negedge clk);
  endtask

  function automatic logic [SBITS-1:0] rand_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return SBITS'($urandom_range(0, (1 << SBITS) - 1));
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stim
    logic [DATA_W-1:0] g;
    logic [DATA_W-1:0] b;
    int n;
    int pick;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Zero block count with gain above one (saturates): the warm-up beat
    // already fires with every channel empty, then each beat fires with
    // only the sampled channel filled.
    apply_settings('1, '0);
    sample_queue.push_back(10'h3FF);
    sample_queue.push_back(10'h000);
    sample_queue.push_back(10'h3FF);
    sample_queue.push_back(10'h3FF);
    sample_queue.push_back(10'h200);
    sample_queue.push_back(10'h155);
    sample_queue.push_back(10'h2AA);

    // Zero gain: levels frozen. Block count 1 written with junk upper bits.
    apply_settings('0, {10'h3FF, 7'd1});
    sample_queue.push_back(10'h3FF);
    sample_queue.push_back(10'h3FF);
    sample_queue.push_back(10'h000);
    sample_queue.push_back(10'h3FF);
    sample_queue.push_back(10'h001);
    sample_queue.push_back(10'h3FE);

    // Tiny gain, then gain just under one, block counts 2 and 3.
    apply_settings(17'd1, 17'd2);
    repeat (6) sample_queue.push_back(10'h3FF);
    apply_settings(17'd65535, 17'd3);
    sample_queue.push_back(10'h000);
    repeat (5) sample_queue.push_back(10'h3FF);

    // Pressure: sender never idles while the receiver is choked, so the
    // finished result waits and the block stops taking samples.
    apply_settings(17'd42598, 17'd1);
    calm      = 1'b1;
    choke_req = 1'b1;
    repeat (60) sample_queue.push_back(rand_sample());
    wait_drained();

    // Largest block count, no idling on either side: one long block.
    apply_settings(17'($urandom_range(1, 65535)), 17'd127);
    repeat (3 * 127 + 9) sample_queue.push_back(rand_sample());
    wait_drained();
    calm = 1'b0;

    // Random phases: mostly short blocks so results stay frequent.
    while (items_sent < 1250) begin
      pick = $urandom_range(0, 5);
      case (pick)
        0:       g = '0;
        1:       g = DATA_W'(adcbas_pkg::GAIN_ONE);
        2:       g = DATA_W'($urandom_range(65537, 131071));
        3:       g = DATA_W'(adcbas_pkg::GAIN_RESET);
        default: g = DATA_W'($urandom_range(1, 65535));
      endcase
      pick = $urandom_range(0, 9);
      n    = $urandom_range(30, 90);
      case (pick)
        0:       b = '0;
        1: begin
          b = DATA_W'($urandom_range(20, 40));
          n = $urandom_range(100, 150);
        end
        default: b = DATA_W'($urandom_range(1, 8));
      endcase
      // sometimes junk above the count field
      if ($urandom_range(0, 1) == 1) b[DATA_W-1:COUNT_W] = 10'($urandom);
      apply_settings(g, b);
      repeat (n) sample_queue.push_back(rand_sample());
    end

    settle();
    if (angle_queue.size() != 0) mismatches += angle_queue.size();
    if (mismatches == 0) begin
      $display("adc_block_average_smoother regression: pass");
    end else begin
      $display("adc_block_average_smoother regression: fail");
    end
    $finish;
  end

  // hang guard, several times the slowest correct run
  initial begin : guard
    #3_000_000;
    $display("adc_block_average_smoother regression: fail");
    $finish;
  end

endmodule

// File: files.f
hdl/adcbas_pkg.sv
hdl/adcbas_divider.sv
hdl/adc_block_average_smoother.sv
hdl/adcbas_checker.sv
sim/adc_block_average_smoother_tb.sv
